FILE: rtl/tpls_pkg.sv
// ----------------------------------------------------------------
// tpls_pkg
// Types, constants and the solve program of the plane fit block.
// ----------------------------------------------------------------
package tpls_pkg;

	localparam int W        = 256;
	localparam int RMS_BITS = 47;
	localparam int RAD_BITS = 2 * RMS_BITS;
	localparam int RF_DEPTH = 32;
	localparam int RF_AW    = $clog2(RF_DEPTH);

	localparam logic [47:0] FIX_MAX = 48'h7FFF_FFFF_FFFF;
	localparam logic [47:0] FIX_MIN = 48'h8000_0000_0000;
	localparam logic [RMS_BITS-1:0] RMS_MAX = {RMS_BITS{1'b1}};

	typedef logic [W-1:0] word_t;
	typedef logic [RF_AW-1:0] raddr_t;

	// register file slots
	localparam raddr_t R_N   = 5'd0;
	localparam raddr_t R_S1  = 5'd1;
	localparam raddr_t R_S2  = 5'd2;
	localparam raddr_t R_SY  = 5'd3;
	localparam raddr_t R_Q11 = 5'd4;
	localparam raddr_t R_Q22 = 5'd5;
	localparam raddr_t R_QYY = 5'd6;
	localparam raddr_t R_P12 = 5'd7;
	localparam raddr_t R_P1Y = 5'd8;
	localparam raddr_t R_P2Y = 5'd9;
	localparam raddr_t R_T   = 5'd10;
	localparam raddr_t R_U   = 5'd11;
	localparam raddr_t R_C11 = 5'd12;
	localparam raddr_t R_C22 = 5'd13;
	localparam raddr_t R_CYY = 5'd14;
	localparam raddr_t R_C12 = 5'd15;
	localparam raddr_t R_C1Y = 5'd16;
	localparam raddr_t R_C2Y = 5'd17;
	localparam raddr_t R_DET = 5'd18;
	localparam raddr_t R_N1  = 5'd19;
	localparam raddr_t R_N2  = 5'd20;
	localparam raddr_t R_AN  = 5'd21;
	localparam raddr_t R_M   = 5'd22;
	localparam raddr_t R_V   = 5'd23;

	// coefficient slots for the fixed-point conversion
	localparam raddr_t SLOT_A  = 5'd0;
	localparam raddr_t SLOT_B1 = 5'd1;
	localparam raddr_t SLOT_B2 = 5'd2;

	typedef enum logic [2:0] {
		OP_END,
		OP_MUL,
		OP_SUB,
		OP_SHLF,
		OP_CLSH,
		OP_CHK,
		OP_FIX,
		OP_SQRT
	} op_t;

	typedef enum logic [3:0] {
		ST_ACC,
		ST_COPY,
		ST_RDA,
		ST_RDB,
		ST_CAPB,
		ST_GO,
		ST_WAIT,
		ST_WR,
		ST_OUT
	} state_t;

	typedef struct packed {
		op_t    op;
		raddr_t ra;
		raddr_t rb;
		raddr_t rd;
	} uop_t;

	typedef struct packed {
		logic [15:0]        count;
		logic signed [31:0] s1;
		logic signed [31:0] s2;
		logic signed [31:0] sy;
		logic signed [46:0] q11;
		logic signed [46:0] q22;
		logic signed [46:0] qyy;
		logic signed [47:0] p12;
		logic signed [47:0] p1y;
		logic signed [47:0] p2y;
		logic               drop;
	} acc_t;

	typedef struct packed {
		op_t    op;
		raddr_t raddr;
		raddr_t waddr;
		logic   we;
		logic   copy;
		logic   cap_a;
		logic   cap_b;
		logic   start;
		logic   clear;
		logic   load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic busy;
		logic singular;
	} dp_sts_t;

	typedef struct packed {
		logic [15:0]         points;
		logic [RMS_BITS-1:0] rms;
		logic [47:0]         slope_second;
		logic [47:0]         slope_first;
		logic [47:0]         intercept;
		logic                singular;
		logic                overflowed;
	} res_t;

	function automatic uop_t ucode(input logic [5:0] pc);
		uop_t u;
		u = '{OP_END, R_N, R_N, R_N};
		case (pc)
			6'd0:  u = '{OP_MUL,  R_N,   R_Q11, R_T};
			6'd1:  u = '{OP_MUL,  R_S1,  R_S1,  R_U};
			6'd2:  u = '{OP_SUB,  R_T,   R_U,   R_C11};
			6'd3:  u = '{OP_MUL,  R_N,   R_Q22, R_T};
			6'd4:  u = '{OP_MUL,  R_S2,  R_S2,  R_U};
			6'd5:  u = '{OP_SUB,  R_T,   R_U,   R_C22};
			6'd6:  u = '{OP_MUL,  R_N,   R_QYY, R_T};
			6'd7:  u = '{OP_MUL,  R_SY,  R_SY,  R_U};
			6'd8:  u = '{OP_SUB,  R_T,   R_U,   R_CYY};
			6'd9:  u = '{OP_MUL,  R_N,   R_P12, R_T};
			6'd10: u = '{OP_MUL,  R_S1,  R_S2,  R_U};
			6'd11: u = '{OP_SUB,  R_T,   R_U,   R_C12};
			6'd12: u = '{OP_MUL,  R_N,   R_P1Y, R_T};
			6'd13: u = '{OP_MUL,  R_S1,  R_SY,  R_U};
			6'd14: u = '{OP_SUB,  R_T,   R_U,   R_C1Y};
			6'd15: u = '{OP_MUL,  R_N,   R_P2Y, R_T};
			6'd16: u = '{OP_MUL,  R_S2,  R_SY,  R_U};
			6'd17: u = '{OP_SUB,  R_T,   R_U,   R_C2Y};
			6'd18: u = '{OP_MUL,  R_C11, R_C22, R_T};
			6'd19: u = '{OP_MUL,  R_C12, R_C12, R_U};
			6'd20: u = '{OP_SUB,  R_T,   R_U,   R_DET};
			6'd21: u = '{OP_CHK,  R_DET, R_DET, R_T};
			6'd22: u = '{OP_MUL,  R_C1Y, R_C22, R_T};
			6'd23: u = '{OP_MUL,  R_C2Y, R_C12, R_U};
			6'd24: u = '{OP_SUB,  R_T,   R_U,   R_N1};
			6'd25: u = '{OP_MUL,  R_C2Y, R_C11, R_T};
			6'd26: u = '{OP_MUL,  R_C1Y, R_C12, R_U};
			6'd27: u = '{OP_SUB,  R_T,   R_U,   R_N2};
			6'd28: u = '{OP_MUL,  R_SY,  R_DET, R_T};
			6'd29: u = '{OP_MUL,  R_N1,  R_S1,  R_U};
			6'd30: u = '{OP_SUB,  R_T,   R_U,   R_V};
			6'd31: u = '{OP_MUL,  R_N2,  R_S2,  R_U};
			6'd32: u = '{OP_SUB,  R_V,   R_U,   R_AN};
			6'd33: u = '{OP_MUL,  R_CYY, R_DET, R_T};
			6'd34: u = '{OP_MUL,  R_N1,  R_C1Y, R_U};
			6'd35: u = '{OP_SUB,  R_T,   R_U,   R_V};
			6'd36: u = '{OP_MUL,  R_N2,  R_C2Y, R_U};
			6'd37: u = '{OP_SUB,  R_V,   R_U,   R_M};
			6'd38: u = '{OP_SHLF, R_N1,  R_N1,  R_T};
			6'd39: u = '{OP_FIX,  R_T,   R_DET, SLOT_B1};
			6'd40: u = '{OP_SHLF, R_N2,  R_N2,  R_T};
			6'd41: u = '{OP_FIX,  R_T,   R_DET, SLOT_B2};
			6'd42: u = '{OP_SHLF, R_AN,  R_AN,  R_T};
			6'd43: u = '{OP_MUL,  R_N,   R_DET, R_U};
			6'd44: u = '{OP_FIX,  R_T,   R_U,   SLOT_A};
			6'd45: u = '{OP_CLSH, R_M,   R_M,   R_V};
			6'd46: u = '{OP_MUL,  R_N,   R_N,   R_T};
			6'd47: u = '{OP_MUL,  R_T,   R_DET, R_U};
			6'd48: u = '{OP_SQRT, R_V,   R_U,   R_T};
			default: u = '{OP_END, R_N, R_N, R_N};
		endcase
		return u;
	endfunction

endpackage

FILE: rtl/tpls_ram.sv
// ----------------------------------------------------------------
// tpls_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------
module tpls_ram #(
	parameter int WIDTH = 256,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: rtl/tpls_acc.sv
// ----------------------------------------------------------------
// tpls_acc
// Running sums, squares and cross products of the incoming points.
// ----------------------------------------------------------------
module tpls_acc import tpls_pkg::*; #(
	parameter int MAX_POINTS  = 65535,
	parameter int SAMPLE_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        clr,
	input  logic [15:0] first_coord,
	input  logic [15:0] second_coord,
	input  logic [15:0] target_value,
	output acc_t        acc
);

	localparam int SH = 16 - SAMPLE_BITS;

	acc_t               acc_q;
	logic [15:0]        t1, t2, ty;
	logic signed [15:0] x1, x2, y;
	logic signed [31:0] p11, p22, pyy, p12, p1y, p2y;

	always_comb begin
		t1  = first_coord << SH;
		t2  = second_coord << SH;
		ty  = target_value << SH;
		x1  = $signed(t1) >>> SH;
		x2  = $signed(t2) >>> SH;
		y   = $signed(ty) >>> SH;
		p11 = x1 * x1;
		p22 = x2 * x2;
		pyy = y * y;
		p12 = x1 * x2;
		p1y = x1 * y;
		p2y = x2 * y;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (clr) begin
			acc_q <= '0;
		end else if (en) begin
			if (acc_q.count < 16'(MAX_POINTS)) begin
				acc_q.count <= acc_q.count + 16'd1;
				acc_q.s1    <= acc_q.s1 + 32'(x1);
				acc_q.s2    <= acc_q.s2 + 32'(x2);
				acc_q.sy    <= acc_q.sy + 32'(y);
				acc_q.q11   <= acc_q.q11 + 47'(p11);
				acc_q.q22   <= acc_q.q22 + 47'(p22);
				acc_q.qyy   <= acc_q.qyy + 47'(pyy);
				acc_q.p12   <= acc_q.p12 + 48'(p12);
				acc_q.p1y   <= acc_q.p1y + 48'(p1y);
				acc_q.p2y   <= acc_q.p2y + 48'(p2y);
			end else begin
				acc_q.drop <= 1'b1;
			end
		end
	end

	assign acc = acc_q;

endmodule

FILE: rtl/tpls_dp.sv
// ----------------------------------------------------------------
// tpls_dp
// Solve datapath: 256-bit register file, shift-add multiplier,
// restoring divider, fixed-point conversion and square root.
// ----------------------------------------------------------------
module tpls_dp import tpls_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic    clk,
	input  logic    arst_n,
	input  dp_cmd_t cmd,
	input  acc_t    acc,
	output dp_sts_t sts,
	output res_t    res
);

	word_t rdata, wdata, copy_val;
	word_t opa_q, opb_q, res_q, mcand_q, mplier_q, mag;
	word_t div_num_q, div_den_q, div_rem_q, div_quo_q, rem_sh;
	logic  div_ge;
	logic  mul_busy_q, div_busy_q, post_q, sq_busy_q;
	logic [7:0] div_cnt_q;
	logic [5:0] sq_cnt_q;
	op_t    op_q;
	raddr_t slot_q;
	logic   neg_q, sat_q, sing_q, drop_q;
	logic [15:0] pts_q;
	logic [47:0] a_q, b1_q, b2_q, fix_val;
	logic        fix_sat;
	logic [RMS_BITS-1:0] rms_q, sq_root_q, root_nx;
	logic [RAD_BITS-1:0] sq_rad_q;
	logic [RMS_BITS+1:0] sq_rem_q, sq_rem_sh, sq_trial;
	logic                sq_ge;
	res_t res_out_q;

	function automatic res_t pack_res(
		input logic [15:0] pts, input logic [RMS_BITS-1:0] rms,
		input logic [47:0] b2, input logic [47:0] b1, input logic [47:0] a,
		input logic sing, input logic ovf
	);
		res_t r;
		r.points       = pts;
		r.rms          = rms;
		r.slope_second = b2;
		r.slope_first  = b1;
		r.intercept    = a;
		r.singular     = sing;
		r.overflowed   = ovf;
		return r;
	endfunction

	always_comb begin
		case (cmd.waddr)
			R_N:   copy_val = {{(W-16){1'b0}}, acc.count};
			R_S1:  copy_val = {{(W-32){acc.s1[31]}}, acc.s1};
			R_S2:  copy_val = {{(W-32){acc.s2[31]}}, acc.s2};
			R_SY:  copy_val = {{(W-32){acc.sy[31]}}, acc.sy};
			R_Q11: copy_val = {{(W-47){acc.q11[46]}}, acc.q11};
			R_Q22: copy_val = {{(W-47){acc.q22[46]}}, acc.q22};
			R_QYY: copy_val = {{(W-47){acc.qyy[46]}}, acc.qyy};
			R_P12: copy_val = {{(W-48){acc.p12[47]}}, acc.p12};
			R_P1Y: copy_val = {{(W-48){acc.p1y[47]}}, acc.p1y};
			R_P2Y: copy_val = {{(W-48){acc.p2y[47]}}, acc.p2y};
			default: copy_val = '0;
		endcase
		wdata = cmd.copy ? copy_val : res_q;
	end

	tpls_ram #(
		.WIDTH(W),
		.DEPTH(RF_DEPTH)
	) u_rf (
		.clk  (clk),
		.we   (cmd.we | cmd.copy),
		.waddr(cmd.waddr),
		.wdata(wdata),
		.raddr(cmd.raddr),
		.rdata(rdata)
	);

	// divider step, conversion and square-root step
	always_comb begin
		rem_sh = {div_rem_q[W-2:0], div_num_q[W-1]};
		div_ge = (rem_sh >= div_den_q);
		mag    = opa_q[W-1] ? -opa_q : opa_q;
		if (!neg_q) begin
			fix_sat = (div_quo_q[W-1:47] != '0);
			fix_val = fix_sat ? FIX_MAX : div_quo_q[47:0];
		end else begin
			fix_sat = (div_quo_q[W-1:48] != '0) || (div_quo_q[47] && (div_quo_q[46:0] != '0));
			fix_val = fix_sat ? FIX_MIN : -div_quo_q[47:0];
		end
		sq_rem_sh = {sq_rem_q[RMS_BITS-1:0], sq_rad_q[RAD_BITS-1 -: 2]};
		sq_trial  = {sq_root_q, 2'b01};
		sq_ge     = (sq_rem_sh >= sq_trial);
		root_nx   = {sq_root_q[RMS_BITS-2:0], sq_ge};
	end

	// control flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_busy_q <= 1'b0;
			div_busy_q <= 1'b0;
			div_cnt_q  <= '0;
			post_q     <= 1'b0;
			sq_busy_q  <= 1'b0;
			sq_cnt_q   <= '0;
		end else begin
			if (cmd.start) begin
				mul_busy_q <= (cmd.op == OP_MUL);
				div_busy_q <= (cmd.op == OP_FIX) || (cmd.op == OP_SQRT);
				div_cnt_q  <= '0;
			end
			if (mul_busy_q && (mplier_q == '0)) begin
				mul_busy_q <= 1'b0;
			end
			if (div_busy_q) begin
				div_cnt_q <= div_cnt_q + 8'd1;
				if (div_cnt_q == 8'(W - 1)) begin
					div_busy_q <= 1'b0;
					post_q     <= 1'b1;
				end
			end
			if (post_q) begin
				post_q <= 1'b0;
				if (op_q == OP_SQRT && div_quo_q[W-1:RAD_BITS] == '0) begin
					sq_busy_q <= 1'b1;
					sq_cnt_q  <= '0;
				end
			end
			if (sq_busy_q) begin
				sq_cnt_q <= sq_cnt_q + 6'd1;
				if (sq_cnt_q == 6'(RMS_BITS - 1)) begin
					sq_busy_q <= 1'b0;
				end
			end
		end
	end

	// operands and results
	always_ff @(posedge clk) begin
		if (cmd.cap_a) begin
			opa_q <= rdata;
		end
		if (cmd.cap_b) begin
			opb_q <= rdata;
		end
		if (cmd.clear) begin
			pts_q  <= acc.count;
			drop_q <= acc.drop;
			sat_q  <= 1'b0;
			sing_q <= 1'b0;
			a_q    <= '0;
			b1_q   <= '0;
			b2_q   <= '0;
			rms_q  <= '0;
		end
		if (cmd.start) begin
			op_q   <= cmd.op;
			slot_q <= cmd.waddr;
			case (cmd.op)
				OP_MUL: begin
					mcand_q  <= opa_q;
					mplier_q <= opb_q;
					res_q    <= '0;
				end
				OP_SUB:  res_q <= opa_q - opb_q;
				OP_SHLF: res_q <= opa_q << FRAC_BITS;
				OP_CLSH: res_q <= opa_q[W-1] ? '0 : (opa_q << (2 * FRAC_BITS));
				OP_CHK: begin
					if (opa_q[W-1] || opa_q == '0) begin
						sing_q <= 1'b1;
					end
				end
				OP_FIX: begin
					neg_q     <= opa_q[W-1];
					div_num_q <= (mag << 1) + opb_q;
					div_den_q <= opb_q << 1;
					div_rem_q <= '0;
				end
				OP_SQRT: begin
					div_num_q <= opa_q;
					div_den_q <= opb_q;
					div_rem_q <= '0;
				end
				default: ;
			endcase
		end
		if (mul_busy_q && (mplier_q != '0)) begin
			if (mplier_q[0]) begin
				res_q <= res_q + mcand_q;
			end
			mcand_q  <= mcand_q << 1;
			mplier_q <= mplier_q >> 1;
		end
		if (div_busy_q) begin
			div_rem_q <= div_ge ? (rem_sh - div_den_q) : rem_sh;
			div_quo_q <= {div_quo_q[W-2:0], div_ge};
			div_num_q <= div_num_q << 1;
		end
		if (post_q) begin
			case (op_q)
				OP_FIX: begin
					if (fix_sat) begin
						sat_q <= 1'b1;
					end
					case (slot_q)
						SLOT_A:  a_q  <= fix_val;
						SLOT_B1: b1_q <= fix_val;
						default: b2_q <= fix_val;
					endcase
				end
				OP_SQRT: begin
					if (div_quo_q[W-1:RAD_BITS] != '0) begin
						sat_q <= 1'b1;
						rms_q <= RMS_MAX;
					end else begin
						sq_rad_q  <= div_quo_q[RAD_BITS-1:0];
						sq_rem_q  <= '0;
						sq_root_q <= '0;
					end
				end
				default: ;
			endcase
		end
		if (sq_busy_q) begin
			sq_rem_q  <= sq_ge ? (sq_rem_sh - sq_trial) : sq_rem_sh;
			sq_root_q <= root_nx;
			sq_rad_q  <= {sq_rad_q[RAD_BITS-3:0], 2'b00};
			if (sq_cnt_q == 6'(RMS_BITS - 1)) begin
				rms_q <= root_nx;
			end
		end
		if (cmd.load_out) begin
			res_out_q <= pack_res(pts_q, rms_q, b2_q, b1_q, a_q, sing_q, drop_q | sat_q);
		end
	end

	assign res          = res_out_q;
	assign sts.busy     = mul_busy_q | div_busy_q | post_q | sq_busy_q;
	assign sts.singular = sing_q;

endmodule

FILE: rtl/tpls_ctrl.sv
// ----------------------------------------------------------------
// tpls_ctrl
// Sequencer: accumulation, copy into the register file, stepping
// through the solve program and handing the result to the output.
// ----------------------------------------------------------------
module tpls_ctrl import tpls_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	input  logic    s_tlast,
	input  logic    m_tready,
	input  dp_sts_t sts,
	output logic    s_tready,
	output logic    m_tvalid,
	output logic    acc_clr,
	output dp_cmd_t cmd
);

	state_t     state_q, state_nx;
	logic [5:0] pc_q, pc_nx;
	raddr_t     cnt_q, cnt_nx;
	logic       mvalid_q;
	uop_t       u;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_ACC;
			pc_q     <= '0;
			cnt_q    <= '0;
			mvalid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			pc_q    <= pc_nx;
			cnt_q   <= cnt_nx;
			if (cmd.load_out) begin
				mvalid_q <= 1'b1;
			end else if (m_tready) begin
				mvalid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		u        = ucode(pc_q);
		state_nx = state_q;
		pc_nx    = pc_q;
		cnt_nx   = cnt_q;
		s_tready = 1'b0;
		acc_clr  = 1'b0;
		cmd      = '0;
		cmd.op   = OP_END;
		cmd.raddr = u.ra;
		case (state_q)
			ST_ACC: begin
				s_tready = 1'b1;
				if (s_tvalid && s_tlast) begin
					cnt_nx   = '0;
					state_nx = ST_COPY;
				end
			end
			ST_COPY: begin
				cmd.copy  = 1'b1;
				cmd.waddr = cnt_q;
				cmd.clear = (cnt_q == R_N);
				cnt_nx    = cnt_q + 5'd1;
				if (cnt_q == R_P2Y) begin
					acc_clr  = 1'b1;
					pc_nx    = '0;
					state_nx = ST_RDA;
				end
			end
			ST_RDA: begin
				cmd.raddr = u.ra;
				state_nx  = (u.op == OP_END) ? ST_OUT : ST_RDB;
			end
			ST_RDB: begin
				cmd.raddr = u.rb;
				cmd.cap_a = 1'b1;
				state_nx  = ST_CAPB;
			end
			ST_CAPB: begin
				cmd.cap_b = 1'b1;
				state_nx  = ST_GO;
			end
			ST_GO: begin
				cmd.start = 1'b1;
				cmd.op    = u.op;
				cmd.waddr = u.rd;
				state_nx  = ST_WAIT;
			end
			ST_WAIT: begin
				if (!sts.busy) begin
					state_nx = ST_WR;
				end
			end
			ST_WR: begin
				cmd.waddr = u.rd;
				cmd.we    = (u.op == OP_MUL) || (u.op == OP_SUB) ||
					(u.op == OP_SHLF) || (u.op == OP_CLSH);
				if (u.op == OP_CHK && sts.singular) begin
					state_nx = ST_OUT;
				end else begin
					pc_nx    = pc_q + 6'd1;
					state_nx = ST_RDA;
				end
			end
			ST_OUT: begin
				if (!mvalid_q || m_tready) begin
					cmd.load_out = 1'b1;
					state_nx     = ST_ACC;
				end
			end
			default: state_nx = ST_ACC;
		endcase
	end

	assign m_tvalid = mvalid_q;

endmodule

FILE: rtl/two_predictor_least_squares_fit_top.sv
// ----------------------------------------------------------------
// two_predictor_least_squares_fit_top
// Least-squares plane fit y = a + b1*x1 + b2*x2 over a stream of points.
// ----------------------------------------------------------------
// Usage:
// points arrive on the slave stream, one request per point (x1, x2, y
// in tdata, tlast on the final point of a set). while accumulating the
// block takes one point per cycle. the request with tlast starts the
// solve, during which s_tready is low: the ten sums are copied into a
// 256-bit register file, then a fixed program of 49 steps runs on one
// shift-add multiplier (27 products), a restoring divider (four
// divides) and a square root; each step passes through fetch and
// write-back states. a singular set stops after the determinant check.
// the result waits in an output register while the next set is
// accumulated, and a stalled receiver only holds back the load of the
// following result. reset clears the sums and drops any pending
// result.
// ----------------------------------------------------------------
module two_predictor_least_squares_fit_top import tpls_pkg::*; #(
	parameter int MAX_POINTS  = 65535,
	parameter int SAMPLE_BITS = 16,
	parameter int FRAC_BITS   = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [47:0]  s_tdata,  // first_coord, second_coord, target_value
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [207:0] m_tdata,  // intercept, slope_first, slope_second, residual_rms, points_used
	output logic [1:0]   m_tuser   // singular, overflowed
);

	acc_t    acc;
	dp_cmd_t cmd;
	dp_sts_t sts;
	res_t    res;
	logic    acc_clr;

	tpls_acc #(
		.MAX_POINTS (MAX_POINTS),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_acc (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (s_tvalid & s_tready),
		.clr         (acc_clr),
		.first_coord (s_tdata[15:0]),
		.second_coord(s_tdata[31:16]),
		.target_value(s_tdata[47:32]),
		.acc         (acc)
	);

	tpls_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tlast (s_tlast),
		.m_tready(m_tready),
		.sts     (sts),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.acc_clr (acc_clr),
		.cmd     (cmd)
	);

	tpls_dp #(
		.FRAC_BITS(FRAC_BITS)
	) u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.acc   (acc),
		.sts   (sts),
		.res   (res)
	);

	assign m_tdata = {1'b0, res.points, res.rms, res.slope_second, res.slope_first,
		res.intercept};
	assign m_tuser = {res.overflowed, res.singular};

endmodule

FILE: rtl/tpls_chk.sv
// ----------------------------------------------------------------
// tpls_chk
// Port-level checks on the plane fit block, bound to the top level.
// ----------------------------------------------------------------
module tpls_chk (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         s_tlast,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [207:0] m_tdata,
	input logic [1:0]   m_tuser
);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// final point of a set starts the solve
	a_solve: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready)
		else $error("input taken during solve");

	// singular fit gives zero coefficients and rms
	a_sing: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[190:0] == '0)
		else $error("singular result not zero");

	// every set has at least one point
	a_pts: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[206:191] != 16'd0)
		else $error("empty point count");

endmodule

bind two_predictor_least_squares_fit_top tpls_chk u_chk (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tlast (s_tlast),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);
